### rtl/core/fsip_pkg.sv
// ----------------------------------------------------------------------------
// fsip_pkg
// Types, character codes and helpers shared by the integer format printer.
// ----------------------------------------------------------------------------
`default_nettype none

package fsip_pkg;

  localparam int ARG_W  = 32;  // width of the argument field
  localparam int CHAR_W = 8;   // width of one character
  localparam int PAD_W  = 5;   // holds a minimum width up to twenty digits

  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LOWER_D = 8'h64;
  localparam logic [CHAR_W-1:0] CH_LOWER_L = 8'h6c;
  localparam logic [CHAR_W-1:0] CH_LOWER_U = 8'h75;
  localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;

  typedef enum logic [1:0] {
    MODE_LITERAL,
    MODE_PERCENT,
    MODE_DIGITS,
    MODE_LENGTH
  } parse_mode_t;

  typedef enum logic {
    CMD_LIT,
    CMD_CONV
  } cmd_kind_t;

  typedef enum logic [1:0] {
    CONV_UDEC,
    CONV_SDEC,
    CONV_HEX
  } conv_t;

  typedef enum logic [1:0] {
    R_IDLE,
    R_DABBLE,
    R_SIGN,
    R_DIGITS
  } rstate_t;

  // One queued job: a single literal character or a conversion.
  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAR_W-1:0] chr;
    conv_t             conv;
    logic [PAD_W-1:0]  width;
    logic [ARG_W-1:0]  arg;
  } cmd_t;

  // Decimal digit count of an all-ones word of the given width.
  function automatic int dec_digits(input int bits);
    logic [63:0] v;
    int          n;
    v = {64{1'b1}} >> (64 - bits);
    n = 1;
    for (int i = 0; i < 20; i++) begin
      if (v >= 64'd10) begin
        v = v / 64'd10;
        n++;
      end
    end
    return n;
  endfunction

  // Upper-case hex or decimal character for one digit.
  function automatic logic [CHAR_W-1:0] nib_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] ext;
    ext = {4'b0000, nib};
    if (nib <= 4'd9) begin
      return CH_ZERO + ext;
    end
    return CH_UPPER_A + ext - 8'd10;
  endfunction

endpackage

`default_nettype wire

### rtl/core/fsip_parser.sv
// ----------------------------------------------------------------------------
// fsip_parser
// Front end: walks the format string and queues literal and conversion jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module fsip_parser import fsip_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fmt_valid,
  output logic              fmt_ready,
  input  logic              first,
  input  logic [CHAR_W-1:0] format_byte,
  input  logic [ARG_W-1:0]  argument,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd
);

  localparam int                DEC_DIGITS = dec_digits(WORD_BITS);
  localparam logic [CHAR_W-1:0] WIDTH_LIM  = CHAR_W'(DEC_DIGITS);

  parse_mode_t       mode, mode_next, mode_cur;
  logic [PAD_W-1:0]  pad_width, pad_width_next, width_cur;
  logic              accept;
  logic              is_conv, is_len, is_digit;
  conv_t             conv_sel;
  logic [CHAR_W-1:0] wide;

  assign fmt_ready = !q_full;
  assign accept    = fmt_valid && fmt_ready;

  always_comb begin
    mode_cur  = first ? MODE_LITERAL : mode;
    width_cur = first ? PAD_W'(1) : pad_width;

    is_conv = (format_byte == CH_LOWER_U) || (format_byte == CH_LOWER_D) ||
              (format_byte == CH_LOWER_X) || (format_byte == CH_UPPER_X);
    is_len   = (format_byte == CH_LOWER_L) || (format_byte == CH_LOWER_Z);
    is_digit = (format_byte >= CH_ZERO) && (format_byte <= CH_NINE);

    priority if (format_byte == CH_LOWER_D) begin
      conv_sel = CONV_SDEC;
    end else if (format_byte == CH_LOWER_U) begin
      conv_sel = CONV_UDEC;
    end else begin
      conv_sel = CONV_HEX;
    end

    // width * 10 + digit; the stored width never exceeds twenty.
    wide = ({3'b000, width_cur} << 3) + ({3'b000, width_cur} << 1) +
           {4'b0000, format_byte[3:0]};

    mode_next      = mode_cur;
    pad_width_next = width_cur;
    q_push         = 1'b0;
    q_cmd.kind     = CMD_LIT;
    q_cmd.chr      = format_byte;
    q_cmd.conv     = conv_sel;
    q_cmd.width    = width_cur;
    q_cmd.arg      = argument;

    if (format_byte == CH_NUL) begin
      mode_next      = MODE_LITERAL;
      pad_width_next = PAD_W'(1);
    end else begin
      unique case (mode_cur)
        MODE_LITERAL: begin
          if (format_byte == CH_PERCENT) begin
            mode_next = MODE_PERCENT;
          end else begin
            q_push = accept;
          end
        end
        MODE_PERCENT: begin
          priority if (format_byte == CH_PERCENT) begin
            q_push         = accept;
            mode_next      = MODE_LITERAL;
            pad_width_next = PAD_W'(1);
          end else if (format_byte == CH_ZERO) begin
            pad_width_next = '0;
            mode_next      = MODE_DIGITS;
          end else if (is_len) begin
            mode_next = MODE_LENGTH;
          end else begin
            q_push         = accept && is_conv;
            q_cmd.kind     = CMD_CONV;
            mode_next      = MODE_LITERAL;
            pad_width_next = PAD_W'(1);
          end
        end
        MODE_DIGITS: begin
          priority if (is_digit) begin
            pad_width_next = (wide > WIDTH_LIM) ? WIDTH_LIM[PAD_W-1:0] : wide[PAD_W-1:0];
          end else if (is_len) begin
            mode_next = MODE_LENGTH;
          end else begin
            q_push         = accept && is_conv;
            q_cmd.kind     = CMD_CONV;
            mode_next      = MODE_LITERAL;
            pad_width_next = PAD_W'(1);
          end
        end
        MODE_LENGTH: begin
          q_push         = accept && is_conv;
          q_cmd.kind     = CMD_CONV;
          mode_next      = MODE_LITERAL;
          pad_width_next = PAD_W'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_LITERAL;
      pad_width <= PAD_W'(1);
    end else if (accept) begin
      mode      <= mode_next;
      pad_width <= pad_width_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/fsip_queue.sv
// ----------------------------------------------------------------------------
// fsip_queue
// Two-entry job queue between the parser and the character renderer.
// ----------------------------------------------------------------------------
`default_nettype none

module fsip_queue import fsip_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  cmd_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

### rtl/core/fsip_render.sv
// ----------------------------------------------------------------------------
// fsip_render
// Back end: turns queued jobs into characters, one per cycle at most.
// ----------------------------------------------------------------------------
`default_nettype none

module fsip_render import fsip_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  cmd_t              q_head,
  output logic              q_pop,
  output logic              chr_valid,
  input  logic              chr_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              last
);

  localparam int ARG_BITS = (WORD_BITS < ARG_W) ? WORD_BITS : ARG_W;
  localparam int NDIG     = dec_digits(WORD_BITS);
  localparam int DIG_W    = NDIG * 4;
  localparam int IDX_W    = $clog2(NDIG);
  localparam int BIT_W    = $clog2(ARG_BITS + 1);
  localparam int HEX_MAX  = WORD_BITS / 4;

  rstate_t             state, state_next;
  logic [DIG_W-1:0]    digs, digs_next, digs_adj;
  logic [ARG_BITS-1:0] shreg, shreg_next;
  logic [BIT_W-1:0]    bitcnt, bitcnt_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [PAD_W-1:0]    effw, effw_next;
  logic                started, started_next;
  logic                neg, neg_next;

  logic                ov, ov_next;
  logic [CHAR_W-1:0]   och, och_next;
  logic                olast, olast_next;

  logic                can_emit;
  logic [ARG_BITS-1:0] arg_v, mag_in;
  logic                neg_in, hex_in;
  logic [PAD_W-1:0]    w1, effw_in;
  logic [3:0]          nib;
  logic                show;

  assign chr_valid = ov;
  assign out_char  = och;
  assign last      = olast;
  assign can_emit  = !ov || chr_ready;

  always_comb begin
    arg_v   = q_head.arg[ARG_BITS-1:0];
    hex_in  = (q_head.conv == CONV_HEX);
    neg_in  = (q_head.conv == CONV_SDEC) && arg_v[ARG_BITS-1];
    mag_in  = neg_in ? (~arg_v + ARG_BITS'(1)) : arg_v;
    w1      = (neg_in && (q_head.width != '0)) ? (q_head.width - PAD_W'(1)) : q_head.width;
    effw_in = (hex_in && (w1 > PAD_W'(HEX_MAX))) ? PAD_W'(HEX_MAX) : w1;

    // Shift-and-add-three step of the binary to BCD conversion.
    for (int d = 0; d < NDIG; d++) begin
      digs_adj[d*4 +: 4] = (digs[d*4 +: 4] >= 4'd5) ? (digs[d*4 +: 4] + 4'd3)
                                                     : digs[d*4 +: 4];
    end

    nib  = digs[{idx, 2'b00} +: 4];
    show = started || (nib != 4'd0) || (idx == '0) ||
           ({{(PAD_W + 1 - IDX_W){1'b0}}, idx} < {1'b0, effw});
  end

  always_comb begin
    state_next   = state;
    digs_next    = digs;
    shreg_next   = shreg;
    bitcnt_next  = bitcnt;
    idx_next     = idx;
    effw_next    = effw;
    started_next = started;
    neg_next     = neg;
    q_pop        = 1'b0;
    och_next     = och;
    olast_next   = olast;
    ov_next      = chr_ready ? 1'b0 : ov;

    unique case (state)
      R_IDLE: begin
        if (q_valid) begin
          if (q_head.kind == CMD_LIT) begin
            if (can_emit) begin
              q_pop      = 1'b1;
              ov_next    = 1'b1;
              och_next   = q_head.chr;
              olast_next = 1'b1;
            end
          end else begin
            q_pop        = 1'b1;
            neg_next     = neg_in;
            effw_next    = effw_in;
            idx_next     = IDX_W'(NDIG - 1);
            started_next = 1'b0;
            if (hex_in) begin
              digs_next  = DIG_W'(mag_in);
              state_next = R_DIGITS;
            end else begin
              digs_next   = '0;
              shreg_next  = mag_in;
              bitcnt_next = BIT_W'(ARG_BITS);
              state_next  = R_DABBLE;
            end
          end
        end
      end
      R_DABBLE: begin
        digs_next   = {digs_adj[DIG_W-2:0], shreg[ARG_BITS-1]};
        shreg_next  = shreg << 1;
        bitcnt_next = bitcnt - BIT_W'(1);
        if (bitcnt == BIT_W'(1)) begin
          state_next = neg ? R_SIGN : R_DIGITS;
        end
      end
      R_SIGN: begin
        if (can_emit) begin
          ov_next    = 1'b1;
          och_next   = CH_MINUS;
          olast_next = 1'b0;
          state_next = R_DIGITS;
        end
      end
      R_DIGITS: begin
        if (show) begin
          if (can_emit) begin
            ov_next      = 1'b1;
            och_next     = nib_char(nib);
            olast_next   = (idx == '0);
            started_next = 1'b1;
            if (idx == '0) begin
              state_next = R_IDLE;
            end else begin
              idx_next = idx - IDX_W'(1);
            end
          end
        end else begin
          // Leading zero above the minimum width: skip it.
          idx_next = idx - IDX_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      ov    <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    digs    <= digs_next;
    shreg   <= shreg_next;
    bitcnt  <= bitcnt_next;
    idx     <= idx_next;
    effw    <= effw_next;
    started <= started_next;
    neg     <= neg_next;
    och     <= och_next;
    olast   <= olast_next;
  end

endmodule

`default_nettype wire

### rtl/core/format_string_integer_printer.sv
// ----------------------------------------------------------------------------
// format_string_integer_printer
// Streaming printf-style formatter for integer conversions.
// ----------------------------------------------------------------------------
// Format bytes are taken on the fmt channel, one request per cycle while the
// two-entry job queue has room; bytes that print nothing are absorbed in that
// cycle. Characters leave on the chr channel, at most one per cycle, with last
// set on the final character of each request. A literal byte goes from the
// queue head straight into the output register. A hex conversion is loaded
// from the queue head and then walks all decimal digit positions of the word
// from the top, one per cycle unless the output sink stalls (ten positions at
// WORD_BITS = 32), emitting from the first significant or width-forced digit
// on. A decimal conversion is loaded the same way, runs a binary to BCD
// converter over every argument bit in turn, then emits an optional sign and
// walks the same ten digit positions; the output sink's ready stalls it.
`default_nettype none

module format_string_integer_printer import fsip_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fmt_valid,
  output logic              fmt_ready,
  input  logic              first,
  input  logic [CHAR_W-1:0] format_byte,
  input  logic [ARG_W-1:0]  argument,
  output logic              chr_valid,
  input  logic              chr_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              last
);

  logic q_full, q_push, q_pop, q_valid;
  cmd_t q_cmd, q_head;

  fsip_parser #(.WORD_BITS(WORD_BITS)) u_parser (
    .clk         (clk),
    .rst         (rst),
    .fmt_valid   (fmt_valid),
    .fmt_ready   (fmt_ready),
    .first       (first),
    .format_byte (format_byte),
    .argument    (argument),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd)
  );

  fsip_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  fsip_render #(.WORD_BITS(WORD_BITS)) u_render (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .chr_valid (chr_valid),
    .chr_ready (chr_ready),
    .out_char  (out_char),
    .last      (last)
  );

endmodule

`default_nettype wire

### rtl/core/fsip_checker.sv
// ----------------------------------------------------------------------------
// fsip_checker
// Port-level checks for the integer format printer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fsip_checker import fsip_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              chr_valid,
  input logic              chr_ready,
  input logic [CHAR_W-1:0] out_char,
  input logic              last
);

  // Nothing is offered in the cycle after reset.
  assert property (@(posedge clk) rst |=> !chr_valid)
    else $error("character offered right after reset");

  // A stalled character holds.
  assert property (@(posedge clk) disable iff (rst)
    chr_valid && !chr_ready |=> chr_valid && $stable(out_char) && $stable(last))
    else $error("stalled character changed");

  // Only conversions give more than one character, so a non-final character
  // is a sign or a digit.
  assert property (@(posedge clk) disable iff (rst)
    chr_valid && !last |-> (out_char == CH_MINUS) ||
      ((out_char >= CH_ZERO) && (out_char <= CH_NINE)) ||
      ((out_char >= CH_UPPER_A) && (out_char <= CH_UPPER_A + 8'd5)))
    else $error("unexpected character inside a conversion");

endmodule

bind format_string_integer_printer fsip_checker u_fsip_checker (.*);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming integer format printer. Format bytes
// go in through a queued driver with random gaps. A predictor tracks the
// directive parser and renders the expected characters for every accepted
// request. A monitor with random backpressure checks the character stream
// in order.
// ----------------------------------------------------------------------------
module tb;
  import fsip_pkg::*;

  localparam int DEC_LIMIT = 10;  // decimal digits in a 32-bit word
  localparam int HEX_LIMIT = 8;   // hex digits in a 32-bit word
  localparam int RANDOM_REQUESTS = 120;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 100;
  localparam logic [CHAR_W-1:0] CH_LOWER_S = 8'h73;

  typedef struct {
    logic              first;
    logic [CHAR_W-1:0] chr;
    logic [ARG_W-1:0]  arg;
    int                gap;
    bit                drain;
  } fmt_req_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } printed_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              fmt_valid = 1'b0;
  logic              fmt_ready;
  logic              first = 1'b0;
  logic [CHAR_W-1:0] format_byte = '0;
  logic [ARG_W-1:0]  argument = '0;
  logic              chr_valid;
  logic              chr_ready = 1'b0;
  logic [CHAR_W-1:0] out_char;
  logic              last;

  fmt_req_t          format_requests[$];
  printed_t          expected_chars[$];
  logic [CHAR_W-1:0] line_chars[$];

  parse_mode_t fmt_mode = MODE_LITERAL;
  int          pad_width = 1;

  int  requests_queued = 0;
  int  requests_taken = 0;
  int  chars_predicted = 0;
  int  chars_checked = 0;
  int  error_count = 0;
  int  gap_count = 0;
  int  sink_wait = 0;
  int  hold_count = 0;
  logic sink_hold = 1'b0;
  logic hold_done = 1'b0;
  bit  steady_feed = 1'b0;
  bit  drain_next = 1'b0;
  bit  drain_done = 1'b0;

  logic [CHAR_W-1:0] conv_letters[4] = '{CH_LOWER_U, CH_LOWER_D, CH_LOWER_X, CH_UPPER_X};

  format_string_integer_printer uut (
    .clk         (clk),
    .rst         (rst),
    .fmt_valid   (fmt_valid),
    .fmt_ready   (fmt_ready),
    .first       (first),
    .format_byte (format_byte),
    .argument    (argument),
    .chr_valid   (chr_valid),
    .chr_ready   (chr_ready),
    .out_char    (out_char),
    .last        (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic restart_parser();
    fmt_mode = MODE_LITERAL;
    pad_width = 1;
  endtask

  // Appends the rendered number to line_chars; letters that are not
  // conversions print nothing.
  task automatic spell_number(input logic [CHAR_W-1:0] c, input logic [ARG_W-1:0] arg);
    logic [ARG_W-1:0]  mag;
    logic [ARG_W-1:0]  tmp;
    logic [3:0]        nib;
    logic [CHAR_W-1:0] digs[0:15];
    int                width;
    int                cnt;
    if (c != CH_LOWER_U && c != CH_LOWER_D && c != CH_LOWER_X && c != CH_UPPER_X) begin
      return;
    end
    width = pad_width;
    mag = arg;
    if (c == CH_LOWER_D && arg[ARG_W-1]) begin
      mag = -arg;
      line_chars.push_back(CH_MINUS);
      if (width > 0) begin
        width--;
      end
    end
    tmp = mag;
    cnt = 1;
    if (c == CH_LOWER_X || c == CH_UPPER_X) begin
      while (tmp >= 16) begin
        tmp = tmp >> 4;
        cnt++;
      end
      if (width > HEX_LIMIT) begin
        width = HEX_LIMIT;
      end
      if (width > cnt) begin
        cnt = width;
      end
      for (int i = cnt - 1; i >= 0; i--) begin
        nib = 4'((mag >> (4 * i)) & 32'hF);
        line_chars.push_back(nib <= 4'd9 ? CH_ZERO + CHAR_W'(nib)
                                         : CH_UPPER_A + CHAR_W'(nib) - 8'd10);
      end
    end else begin
      while (tmp >= 10) begin
        tmp = tmp / 10;
        cnt++;
      end
      if (width > cnt) begin
        cnt = width;
      end
      for (int i = 0; i < cnt; i++) begin
        digs[i] = CH_ZERO + CHAR_W'(mag % 10);
        mag = mag / 10;
      end
      for (int i = cnt - 1; i >= 0; i--) begin
        line_chars.push_back(digs[i]);
      end
    end
  endtask

  // Advances the parser by one format byte and queues what it prints.
  task automatic render_request(input logic f, input logic [CHAR_W-1:0] c,
                                input logic [ARG_W-1:0] arg);
    printed_t p;
    int       w;
    line_chars.delete();
    if (f) begin
      restart_parser();
    end
    if (c == CH_NUL) begin
      restart_parser();
    end else begin
      case (fmt_mode)
        MODE_LITERAL: begin
          if (c == CH_PERCENT) begin
            fmt_mode = MODE_PERCENT;
          end else begin
            line_chars.push_back(c);
          end
        end
        MODE_PERCENT: begin
          if (c == CH_PERCENT) begin
            line_chars.push_back(CH_PERCENT);
            restart_parser();
          end else if (c == CH_ZERO) begin
            pad_width = 0;
            fmt_mode = MODE_DIGITS;
          end else if (c == CH_LOWER_L || c == CH_LOWER_Z) begin
            fmt_mode = MODE_LENGTH;
          end else begin
            spell_number(c, arg);
            restart_parser();
          end
        end
        MODE_DIGITS: begin
          if (c >= CH_ZERO && c <= CH_NINE) begin
            w = pad_width * 10 + int'(c - CH_ZERO);
            pad_width = (w > DEC_LIMIT) ? DEC_LIMIT : w;
          end else if (c == CH_LOWER_L || c == CH_LOWER_Z) begin
            fmt_mode = MODE_LENGTH;
          end else begin
            spell_number(c, arg);
            restart_parser();
          end
        end
        default: begin
          spell_number(c, arg);
          restart_parser();
        end
      endcase
    end
    for (int i = 0; i < line_chars.size(); i++) begin
      p.ch = line_chars[i];
      p.last = (i == line_chars.size() - 1);
      expected_chars.push_back(p);
      chars_predicted++;
    end
  endtask

  task automatic add_request(input logic f, input logic [CHAR_W-1:0] c,
                             input logic [ARG_W-1:0] arg);
    fmt_req_t r;
    r.first = f;
    r.chr = c;
    r.arg = arg;
    r.gap = steady_feed ? 0 : $urandom_range(0, 5);
    r.drain = drain_next;
    drain_next = 1'b0;
    format_requests.push_back(r);
    requests_queued++;
  endtask

  function automatic logic [ARG_W-1:0] pick_argument();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return $urandom_range(0, 99);
      4: return -$urandom_range(1, 99);
      default: return $urandom;
    endcase
  endfunction

  // Driver: presents queued requests with per-request gaps.
  always @(posedge clk) begin
    if (rst) begin
      fmt_valid <= 1'b0;
      gap_count <= 0;
    end else begin
      if (fmt_valid && fmt_ready) begin
        render_request(first, format_byte, argument);
        requests_taken <= requests_taken + 1;
      end
      if (!fmt_valid || fmt_ready) begin
        if (format_requests.size() == 0 ||
            (format_requests[0].drain && chars_predicted != chars_checked)) begin
          fmt_valid <= 1'b0;
        end else if (gap_count < format_requests[0].gap) begin
          gap_count <= gap_count + 1;
          fmt_valid <= 1'b0;
        end else begin
          fmt_valid <= 1'b1;
          first <= format_requests[0].first;
          format_byte <= format_requests[0].chr;
          argument <= format_requests[0].arg;
          gap_count <= 0;
          void'(format_requests.pop_front());
        end
      end
    end
  end

  // One long sink stall once the stream is well under way.
  always @(posedge clk) begin
    if (rst) begin
      sink_hold <= 1'b0;
      hold_count <= 0;
      hold_done <= 1'b0;
    end else if (sink_hold) begin
      if (hold_count == SINK_HOLD_CYCLES) begin
        sink_hold <= 1'b0;
        hold_done <= 1'b1;
      end
      hold_count <= hold_count + 1;
    end else if (!hold_done && requests_taken >= 60) begin
      sink_hold <= 1'b1;
    end
  end

  // Monitor: checks characters in order and draws a stall after each one.
  always @(posedge clk) begin : char_sink
    int       wait_n;
    printed_t exp;
    if (rst) begin
      chr_ready <= 1'b0;
      sink_wait <= 0;
    end else begin
      if (chr_valid && chr_ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character: out_char=%h last=%b", out_char, last);
          error_count++;
        end else begin
          exp = expected_chars.pop_front();
          chars_checked <= chars_checked + 1;
          if (out_char !== exp.ch) begin
            $error("out_char: expected %h, got %h", exp.ch, out_char);
            error_count++;
          end
          if (last !== exp.last) begin
            $error("last: expected %b, got %b", exp.last, last);
            error_count++;
          end
        end
        // Every so often the sink takes a run of characters back to back.
        wait_n = ((chars_checked % 160) < 40) ? 0 : $urandom_range(0, 5);
      end else if (sink_wait > 0) begin
        wait_n = sink_wait - 1;
      end else begin
        wait_n = 0;
      end
      sink_wait <= wait_n;
      chr_ready <= (wait_n == 0) && !sink_hold;
    end
  end

  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    int n_digits;
    // Directed part: a letter and the top of the byte range as literals, escapes,
    // sign and saturation corners, swallowed letters and early string ends.
    add_request(1'b1, CH_UPPER_A, '0);
    add_request(1'b0, 8'hFF, '1);
    add_request(1'b0, CH_PERCENT, '0);
    add_request(1'b0, CH_PERCENT, '0);
    add_request(1'b0, CH_PERCENT, '0);
    add_request(1'b0, CH_LOWER_D, 32'h8000_0000);
    add_request(1'b0, CH_PERCENT, '0);
    add_request(1'b0, CH_ZERO, '0);
    add_request(1'b0, CH_ZERO + 8'd1, '0);
    add_request(1'b0, CH_ZERO + 8'd2, '0);
    add_request(1'b0, CH_LOWER_X, '0);
    add_request(1'b0, CH_PERCENT, '0);
    add_request(1'b0, CH_ZERO, '0);
    add_request(1'b0, CH_LOWER_D, '0);
    add_request(1'b0, CH_PERCENT, '0);
    add_request(1'b0, CH_LOWER_Z, '0);
    add_request(1'b0, CH_LOWER_U, '1);
    add_request(1'b0, CH_PERCENT, '0);
    add_request(1'b0, CH_ZERO, '0);
    add_request(1'b0, CH_ZERO + 8'd5, '0);
    add_request(1'b0, CH_LOWER_D, -32'sd3);
    add_request(1'b0, CH_PERCENT, '0);
    add_request(1'b0, CH_LOWER_L, '0);
    add_request(1'b0, CH_UPPER_X, 32'hDEAD_BEEF);
    add_request(1'b0, CH_PERCENT, '0);
    add_request(1'b0, CH_LOWER_S, '1);
    add_request(1'b0, CH_PERCENT, '0);
    add_request(1'b0, CH_NUL, '1);
    add_request(1'b0, CH_PERCENT, '0);
    add_request(1'b0, CH_ZERO, '0);
    add_request(1'b1, CH_ZERO + 8'd7, '0);

    // Random part: mostly complete directives with random widths and values.
    while (requests_queued < RANDOM_REQUESTS + 31) begin
      steady_feed = (requests_queued >= 110 && requests_queued < 140);
      if (!drain_done && requests_queued >= 130) begin
        drain_next = 1'b1;
        drain_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          add_request($urandom_range(0, 15) == 0, CHAR_W'($urandom_range(1, 255)),
                      $urandom);
        end
        2, 3, 4, 5, 6, 7: begin
          add_request($urandom_range(0, 15) == 0, CH_PERCENT, $urandom);
          if ($urandom_range(0, 2) != 0) begin
            add_request(1'b0, CH_ZERO, $urandom);
            n_digits = $urandom_range(0, 3);
            for (int i = 0; i < n_digits; i++) begin
              add_request(1'b0, CH_ZERO + CHAR_W'($urandom_range(0, 9)), $urandom);
            end
          end
          if ($urandom_range(0, 2) == 0) begin
            add_request(1'b0, $urandom_range(0, 1) ? CH_LOWER_L : CH_LOWER_Z, $urandom);
          end
          add_request(1'b0, conv_letters[$urandom_range(0, 3)], pick_argument());
        end
        8: begin
          add_request(1'b0, CH_PERCENT, $urandom);
          add_request(1'b0, $urandom_range(0, 1) ? CH_PERCENT : CHAR_W'($urandom),
                      pick_argument());
        end
        default: begin
          add_request(1'($urandom_range(0, 1)), $urandom_range(0, 1) ? CH_NUL
                                                                     : CHAR_W'($urandom),
                      $urandom);
        end
      endcase
    end
    steady_feed = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (requests_taken != requests_queued);
    while (chars_predicted != chars_checked) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/fsip_pkg.sv
rtl/core/fsip_parser.sv
rtl/core/fsip_queue.sv
rtl/core/fsip_render.sv
rtl/core/format_string_integer_printer.sv
rtl/core/fsip_checker.sv
tb/tb.sv
